// ===== hdl/mrpt_pkg.sv =====
// Package for the Miller-Rabin prime test block: controller states,
// field widths, trial-division primes and witness bases.
// No dependencies.
`timescale 1ns / 1ps

package mrpt_pkg;

  localparam int unsigned CandW     = 63;
  localparam int unsigned CntW      = 6;   // counts bit positions 0..62
  localparam int unsigned NumPrimes = 10;
  localparam int unsigned PrimeW    = 5;
  localparam int unsigned NumBases  = 7;
  localparam int unsigned BaseIdxW  = 3;
  localparam int unsigned BaseW     = 31;
  localparam logic [CandW-1:0] SmallLimit = CandW'(31 * 31);
  localparam logic [CntW-1:0]  LastBit    = CntW'(CandW - 1);
  localparam logic [BaseIdxW-1:0] LastBase = BaseIdxW'(NumBases - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIEVE,
    S_CLASS,
    S_SPLIT,
    S_BASE,
    S_BASE_W,
    S_POW,
    S_PY_W,
    S_PX,
    S_PX_W,
    S_WIT,
    S_WLOOP,
    S_WSQ_W,
    S_NEXT,
    S_DONE
  } state_e;

  function automatic logic [PrimeW-1:0] small_prime(input int unsigned idx);
    logic [PrimeW-1:0] p;
    unique case (idx)
      0:       p = PrimeW'(2);
      1:       p = PrimeW'(3);
      2:       p = PrimeW'(5);
      3:       p = PrimeW'(7);
      4:       p = PrimeW'(11);
      5:       p = PrimeW'(13);
      6:       p = PrimeW'(17);
      7:       p = PrimeW'(19);
      8:       p = PrimeW'(23);
      default: p = PrimeW'(29);
    endcase
    return p;
  endfunction

  function automatic logic [BaseW-1:0] mr_base(input logic [BaseIdxW-1:0] idx);
    logic [BaseW-1:0] b;
    unique case (idx)
      3'd0:    b = BaseW'(2);
      3'd1:    b = BaseW'(325);
      3'd2:    b = BaseW'(9375);
      3'd3:    b = BaseW'(28178);
      3'd4:    b = BaseW'(450775);
      3'd5:    b = BaseW'(9780504);
      default: b = BaseW'(1795265022);
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle,
// MSB first. Requires a < m. Depends on mrpt_pkg.
`timescale 1ns / 1ps

module mrpt_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mrpt_pkg::CandW-1:0] a_i,
  input  logic [mrpt_pkg::CandW-1:0] b_i,
  input  logic [mrpt_pkg::CandW-1:0] m_i,
  output logic                      done_o,
  output logic [mrpt_pkg::CandW-1:0] result_o
);
  import mrpt_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CandW-1:0] r_q, r_d;
  logic [CandW-1:0] b_q, b_d;
  logic [CandW-1:0] a_q, a_d;
  logic [CandW-1:0] m_q, m_d;
  logic [CandW:0]   dbl, dbl_red, sum;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = dbl_red + (b_q[CandW-1] ? {1'b0, a_q} : '0);
    if (sum >= {1'b0, m_q}) begin
      sum = sum - {1'b0, m_q};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    b_d    = b_q;
    a_d    = a_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      b_d    = b_i;
      a_d    = a_i;
      m_d    = m_i;
    end else if (busy_q) begin
      r_d   = sum[CandW-1:0];
      b_d   = {b_q[CandW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastBit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
    a_q <= a_d;
    m_q <= m_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule

// ===== hdl/miller_rabin_prime_test.sv =====
// Deterministic Miller-Rabin primality test for 63-bit candidates.
// Uses mrpt_pkg and mrpt_mulmod.
//
// One request carries a candidate; one result says whether it is prime.
// The block works on one candidate at a time and holds in_stall_o high
// until the verdict is registered. Trial division by 2..29 runs bit-serially;
// composites with a small factor and small primes finish there. Larger
// candidates run the witness loop over seven bases on one bit-serial
// modular multiplier. The multiplier sets the rate.
`timescale 1ns / 1ps

module miller_rabin_prime_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mrpt_pkg::CandW-1:0] candidate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_prime_o
);
  import mrpt_pkg::*;

  state_e state_q, state_d;

  logic [CandW-1:0]    n_q, sh_q, d_q, nm1_q, x_q, acc_q;
  logic [CntW-1:0]     cnt_q, s_q, r_q;
  logic [BaseIdxW-1:0] idx_q;
  logic [PrimeW-1:0]   res_q [NumPrimes];
  logic                verdict_q;
  logic                out_valid_q;
  logic                is_prime_q;

  logic             mul_start, mul_done;
  logic [CandW-1:0] mul_a, mul_b, mul_res;

  logic any_eq, any_zero;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    any_eq   = 1'b0;
    any_zero = 1'b0;
    for (int i = 0; i < NumPrimes; i++) begin
      if (n_q == CandW'(small_prime(i))) any_eq = 1'b1;
      if (res_q[i] == '0) any_zero = 1'b1;
    end
  end

  mrpt_mulmod u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .m_i      (n_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SIEVE;
      S_SIEVE:  if (cnt_q == LastBit) state_d = S_CLASS;
      S_CLASS: begin
        priority if (n_q < CandW'(2)) state_d = S_DONE;
        else if (any_eq)              state_d = S_DONE;
        else if (any_zero)            state_d = S_DONE;
        else if (n_q < SmallLimit)    state_d = S_DONE;
        else                          state_d = S_SPLIT;
      end
      S_SPLIT:  if (d_q[0]) state_d = S_BASE;
      S_BASE:   state_d = S_BASE_W;
      S_BASE_W: if (mul_done) state_d = (mul_res == '0) ? S_NEXT : S_POW;
      S_POW: begin
        priority if (d_q == '0) state_d = S_WIT;
        else if (d_q[0])        state_d = S_PY_W;
        else                    state_d = S_PX;
      end
      S_PY_W:   if (mul_done) state_d = S_PX;
      S_PX:     state_d = S_PX_W;
      S_PX_W:   if (mul_done) state_d = S_POW;
      S_WIT:    state_d = (acc_q == CandW'(1)) ? S_NEXT : S_WLOOP;
      S_WLOOP: begin
        priority if (r_q == s_q) state_d = S_DONE;
        else if (acc_q == nm1_q) state_d = S_NEXT;
        else                     state_d = S_WSQ_W;
      end
      S_WSQ_W:  if (mul_done) state_d = S_WLOOP;
      S_NEXT:   state_d = (idx_q == LastBase) ? S_DONE : S_BASE;
      S_DONE:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = x_q;
    mul_b     = x_q;
    unique case (state_q)
      S_BASE: begin
        mul_start = 1'b1;
        mul_a     = CandW'(1);
        mul_b     = CandW'(mr_base(idx_q));
      end
      S_POW: begin
        mul_start = (d_q != '0) && d_q[0];
        mul_a     = acc_q;
        mul_b     = x_q;
      end
      S_PX: begin
        mul_start = 1'b1;
      end
      S_WLOOP: begin
        mul_start = (r_q != s_q) && (acc_q != nm1_q);
        mul_a     = acc_q;
        mul_b     = acc_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        n_q   <= candidate_i;
        sh_q  <= candidate_i;
        cnt_q <= '0;
        for (int i = 0; i < NumPrimes; i++) res_q[i] <= '0;
      end
      S_SIEVE: begin
        for (int i = 0; i < NumPrimes; i++) begin
          logic [PrimeW:0] t;
          t = {res_q[i], sh_q[CandW-1]};
          if (t >= {1'b0, small_prime(i)}) t = t - {1'b0, small_prime(i)};
          res_q[i] <= t[PrimeW-1:0];
        end
        sh_q  <= {sh_q[CandW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      S_CLASS: begin
        verdict_q <= (n_q >= CandW'(2)) && (any_eq || !any_zero);
        d_q       <= n_q - CandW'(1);
        nm1_q     <= n_q - CandW'(1);
        s_q       <= '0;
        idx_q     <= '0;
      end
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_q <= {1'b0, d_q[CandW-1:1]};
          s_q <= s_q + 1'b1;
        end else begin
          sh_q <= d_q;  // keep the odd part for each base
        end
      end
      S_BASE_W: begin
        if (mul_done) begin
          x_q   <= mul_res;
          acc_q <= CandW'(1);
          d_q   <= sh_q;
        end
      end
      S_PY_W: if (mul_done) acc_q <= mul_res;
      S_PX_W: begin
        if (mul_done) begin
          x_q <= mul_res;
          d_q <= {1'b0, d_q[CandW-1:1]};
        end
      end
      S_WIT: r_q <= '0;
      S_WLOOP: if (r_q == s_q) verdict_q <= 1'b0;
      S_WSQ_W: begin
        if (mul_done) begin
          acc_q <= mul_res;
          r_q   <= r_q + 1'b1;
        end
      end
      S_NEXT: begin
        if (idx_q == LastBase) verdict_q <= 1'b1;
        else                   idx_q <= idx_q + 1'b1;
      end
      S_DONE: if (!out_valid_q || !out_stall_i) is_prime_q <= verdict_q;
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  a_start_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> !mul_start)
    else $error("multiplier restarted back to back");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_BASE_W || state_q == S_PY_W ||
                  state_q == S_PX_W || state_q == S_WSQ_W))
    else $error("product finished outside a wait state");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result raised without a finished test");

endmodule

// ===== tb/testbench.sv =====
// Testbench for miller_rabin_prime_test: random and directed 63-bit candidates,
// verdicts checked against an in-bench primality predictor.
// Depends on mrpt_pkg and the miller_rabin_prime_test RTL.
`timescale 1ns / 1ps

module testbench;
  import mrpt_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CandW-1:0] candidate_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             is_prime_o;

  miller_rabin_prime_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .candidate_i (candidate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_prime_o  (is_prime_o)
  );

  logic [CandW-1:0] pending_cands[$];
  logic [CandW-1:0] sent_cands[$];
  logic             verdicts_due[$];
  int               n_loaded;
  int               n_accepted;
  int               n_checked;
  int               n_primes;
  int               n_errors;
  int               gap_cnt;
  int               stall_cnt;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(input logic [63:0] x, input logic [63:0] e,
                                          input logic [63:0] m);
    logic [63:0] y;
    logic [63:0] b;
    logic [63:0] k;
    y = 64'd1 % m;
    b = x % m;
    k = e;
    while (k != 0) begin
      if (k[0]) y = mul_mod(y, b, m);
      b = mul_mod(b, b, m);
      k = k >> 1;
    end
    return y;
  endfunction

  function automatic logic primality(input logic [CandW-1:0] cand);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] cur;
    logic [63:0] divs[10];
    logic [63:0] bases[7];
    int          s;
    logic        witness;
    divs  = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
    bases = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    n = {1'b0, cand};
    if (n < 2) return 1'b0;
    foreach (divs[i]) begin
      if (n == divs[i]) return 1'b1;
      if (n % divs[i] == 0) return 1'b0;
    end
    if (n < 64'd961) return 1'b1;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (bases[i]) begin
      a = bases[i] % n;
      if (a != 0) begin
        cur = pow_mod(a, d, n);
        witness = (cur != 1);
        for (int r = 0; r < s && witness; r++) begin
          if (cur == n - 1) witness = 1'b0;
          else cur = mul_mod(cur, cur, n);
        end
        if (witness) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic int draw_wait();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      candidate_i <= '0;
      gap_cnt     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sent_cands   = {sent_cands, candidate_i};
        verdicts_due = {verdicts_due, primality(candidate_i)};
        n_accepted <= n_accepted + 1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_cnt != 0) begin
          in_valid_i <= 1'b0;
          gap_cnt    <= gap_cnt - 1;
        end else if (pending_cands.size() != 0) begin
          in_valid_i  <= 1'b1;
          candidate_i <= pending_cands.pop_front();
          gap_cnt     <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("verdict with no request outstanding");
        end else begin
          logic [CandW-1:0] c;
          logic             v;
          c = sent_cands.pop_front();
          v = verdicts_due.pop_front();
          if (is_prime_o !== v)
            report_mismatch($sformatf("candidate %0d: is_prime %b, want %b", c, is_prime_o, v));
          if (v) n_primes <= n_primes + 1;
        end
        n_checked <= n_checked + 1;
        stall_cnt <= draw_wait();
        out_stall_i <= 1'b0;
      end else if (stall_cnt != 0) begin
        out_stall_i <= 1'b1;
        stall_cnt   <= stall_cnt - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [CandW-1:0] random_cand();
    logic [CandW-1:0] v;
    int               w;
    v = CandW'({$urandom(), $urandom()});
    w = $urandom_range(1, CandW);
    if ($urandom_range(0, 3) != 0) v = v >> (CandW - w);
    if ($urandom_range(0, 1) == 1) v[0] = 1'b1;
    return v;
  endfunction

  initial begin
    logic [CandW-1:0] directed[$];
    n_loaded = 0; n_accepted = 0; n_checked = 0; n_primes = 0; n_errors = 0;
    rst_ni = 1'b0;
    directed = '{0, 1, 2, 3, 4, 29, 31, 841, 899, 960, 961, 967, 2047, 1373653,
                 63'd3215031751, 407521, 897632511, 63'd2305843009213693951,
                 63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFFF,
                 63'h7FFF_FFFF_FFFF_FFFE, 63'h5555_5555_5555_5555,
                 63'd4611686018427387847};
    foreach (directed[i]) pending_cands = {pending_cands, directed[i]};
    repeat (77) pending_cands = {pending_cands, random_cand()};
    n_loaded = pending_cands.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_accepted == n_loaded && verdicts_due.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Tested %0d candidates (%0d directed edge values and pseudoprimes, rest random),",
             n_checked, directed.size());
    $display("with random request gaps and result stalls; %0d were prime.", n_primes);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout: run did not complete");
    $display("Mismatches found");
    $finish;
  end

endmodule
